// ===== design/ipv4hc_pkg.sv =====
// shared types, constants and the ones' complement add for the ipv4 header checker
`default_nettype none

package ipv4hc_pkg;

  localparam logic [3:0] IpVersionOk   = 4'd4;
  localparam logic [3:0] MinIhl        = 4'd5;
  localparam logic [15:0] OnesMask     = 16'hffff;
  localparam logic [7:0] ProtoNumIcmp  = 8'd1;
  localparam logic [7:0] ProtoNumTcp   = 8'd6;
  localparam logic [4:0] ProtoWordIdx  = 5'd4;

  typedef enum logic [2:0] {
    VERDICT_OK_ICMP      = 3'd0,
    VERDICT_OK_TCP       = 3'd1,
    VERDICT_OK_OTHER     = 3'd2,
    VERDICT_BAD_VERSION  = 3'd3,
    VERDICT_BAD_HLEN     = 3'd4,
    VERDICT_BAD_CHECKSUM = 3'd5
  } verdict_e;

  typedef struct packed {
    verdict_e   verdict;
    logic [7:0] protocol;
    logic [5:0] header_bytes;
  } result_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ===== design/ipv4hc_hdr.sv =====
// header state, checksum accumulation and verdict logic for one word per step
`default_nettype none

module ipv4hc_hdr (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [15:0]          word_i,
  input  logic                 first_i,
  output logic                 emit_o,
  output ipv4hc_pkg::result_t  result_o
);
  import ipv4hc_pkg::*;

  logic        in_header_q, in_header_d;
  logic [4:0]  word_count_q, word_count_d;
  logic [4:0]  header_words_q, header_words_d;
  logic [15:0] running_sum_q, running_sum_d;
  logic [7:0]  protocol_seen_q, protocol_seen_d;

  logic [3:0]  version;
  logic [3:0]  ihl;
  logic [15:0] sum_add;

  assign version = word_i[15:12];
  assign ihl     = word_i[11:8];
  assign sum_add = ones_add(running_sum_q, word_i);

  always_comb begin
    in_header_d     = in_header_q;
    word_count_d    = word_count_q;
    header_words_d  = header_words_q;
    running_sum_d   = running_sum_q;
    protocol_seen_d = protocol_seen_q;
    emit_o          = 1'b0;
    result_o.verdict      = VERDICT_OK_OTHER;
    result_o.protocol     = 8'd0;
    result_o.header_bytes = {ihl, 2'b00};
    if (first_i) begin
      in_header_d     = 1'b0;
      word_count_d    = 5'd0;
      header_words_d  = 5'd0;
      running_sum_d   = 16'd0;
      protocol_seen_d = 8'd0;
      if (version != IpVersionOk) begin
        emit_o           = 1'b1;
        result_o.verdict = VERDICT_BAD_VERSION;
      end else if (ihl < MinIhl) begin
        emit_o           = 1'b1;
        result_o.verdict = VERDICT_BAD_HLEN;
      end else begin
        in_header_d    = 1'b1;
        header_words_d = {ihl, 1'b0};
        running_sum_d  = word_i;
        word_count_d   = 5'd1;
      end
    end else if (in_header_q) begin
      running_sum_d = sum_add;
      if (word_count_q == ProtoWordIdx) begin
        protocol_seen_d = word_i[7:0];
      end
      word_count_d = word_count_q + 5'd1;
      if (word_count_d == header_words_q) begin
        in_header_d           = 1'b0;
        emit_o                = 1'b1;
        result_o.protocol     = protocol_seen_d;
        result_o.header_bytes = {header_words_q, 1'b0};
        priority if (sum_add != OnesMask) begin
          result_o.verdict = VERDICT_BAD_CHECKSUM;
        end else if (protocol_seen_d == ProtoNumIcmp) begin
          result_o.verdict = VERDICT_OK_ICMP;
        end else if (protocol_seen_d == ProtoNumTcp) begin
          result_o.verdict = VERDICT_OK_TCP;
        end else begin
          result_o.verdict = VERDICT_OK_OTHER;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q     <= 1'b0;
      word_count_q    <= 5'd0;
      header_words_q  <= 5'd0;
      running_sum_q   <= 16'd0;
      protocol_seen_q <= 8'd0;
    end else if (step_i) begin
      in_header_q     <= in_header_d;
      word_count_q    <= word_count_d;
      header_words_q  <= header_words_d;
      running_sum_q   <= running_sum_d;
      protocol_seen_q <= protocol_seen_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ipv4_header_receive_checker_unit.sv =====
// top level of the ipv4 header receive checker
`default_nettype none

// Checks IPv4 headers arriving as 16-bit network-order words, one request per
// word with the first word of a packet flagged. A word is taken every cycle
// unless its verdict meets a stalled output: each word passes an input register,
// then one stage that does the 16-bit end-around-carry add and the header state
// update, then the result register, which holds a verdict until it is taken.
// A bad version or a header under 20 bytes is reported on the first word;
// otherwise one verdict follows the last header word. Payload words give
// no result. A flagged word drops an unfinished header silently.
module ipv4_header_receive_checker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] word_i,
  input  logic        first_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  verdict_o,
  output logic [7:0]  protocol_o,
  output logic [5:0]  header_bytes_o
);
  import ipv4hc_pkg::*;

  logic        in_valid_q;
  logic [15:0] word_q;
  logic        first_q;
  logic        out_valid_q;
  result_t     result_q;
  result_t     result;
  logic        emit;
  logic        advance;

  ipv4hc_hdr u_hdr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (word_q),
    .first_i  (first_q),
    .emit_o   (emit),
    .result_o (result)
  );

  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q  <= word_i;
      first_q <= first_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      result_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = result_q.verdict;
  assign protocol_o     = result_q.protocol;
  assign header_bytes_o = result_q.header_bytes;

endmodule

`default_nettype wire

// ===== design/ipv4hc_checker.sv =====
// port-level assertions for the ipv4 header receive checker and their bind
`default_nettype none

module ipv4hc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  verdict_o,
  input logic [7:0]  protocol_o,
  input logic [5:0]  header_bytes_o
);
  import ipv4hc_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(verdict_o) &&
      $stable(protocol_o) && $stable(header_bytes_o))
    else $error("stalled result changed");

  // early rejects carry no protocol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_BAD_VERSION || verdict_o == VERDICT_BAD_HLEN)
      |-> protocol_o == 8'd0)
    else $error("early reject with protocol");

  // full header verdicts come only from headers of at least 20 bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VERDICT_OK_ICMP || verdict_o == VERDICT_OK_TCP ||
      verdict_o == VERDICT_OK_OTHER || verdict_o == VERDICT_BAD_CHECKSUM)
      |-> header_bytes_o >= 6'd20 && header_bytes_o[1:0] == 2'b00)
    else $error("full verdict with short header");

  // ok verdicts agree with the protocol byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o != VERDICT_OK_ICMP || protocol_o == ProtoNumIcmp) &&
      (verdict_o != VERDICT_OK_TCP || protocol_o == ProtoNumTcp) &&
      (verdict_o != VERDICT_OK_OTHER ||
        (protocol_o != ProtoNumIcmp && protocol_o != ProtoNumTcp)))
    else $error("verdict does not match protocol");

  // with an empty output the input always takes a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind ipv4_header_receive_checker_unit ipv4hc_checker u_ipv4hc_checker (.*);

`default_nettype wire

// ===== tb/sv/ipv4_header_receive_checker_unit_tb.sv =====
// self-checking testbench for the ipv4 header receive checker: directed table, random packets
module ipv4_header_receive_checker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipv4hc_pkg::*;

  localparam int ItemTarget = 1350;
  localparam int CycleLimit = 200000;
  localparam int LongHold   = 400;

  typedef struct packed {
    logic [15:0] word;
    logic        first;
    logic        typed;
    result_t     want;
  } stim_row_t;

  localparam result_t NoRes = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] word_i = '0;
  logic        first_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  verdict_o;
  logic [7:0]  protocol_o;
  logic [5:0]  header_bytes_o;

  ipv4_header_receive_checker_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .word_i         (word_i),
    .first_i        (first_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .verdict_o      (verdict_o),
    .protocol_o     (protocol_o),
    .header_bytes_o (header_bytes_o)
  );

  always #10 clk_i = ~clk_i;

  // predicted header state
  logic        hdr_open = 1'b0;
  logic [4:0]  hdr_taken = '0;
  logic [4:0]  hdr_len_words = '0;
  logic [15:0] hdr_sum = '0;
  logic [7:0]  hdr_proto = '0;

  result_t     verdict_q [$];
  int          errors = 0;
  int          sent_items = 0;
  int          cycle_cnt = 0;
  bit          tx_gapless = 1'b0;
  bit          rx_hold_req = 1'b0;

  stim_row_t dir_rows [28] = '{
    '{16'h0000, 1'b1, 1'b1, {VERDICT_BAD_VERSION, 8'h00, 6'd0}},
    '{16'hffff, 1'b1, 1'b1, {VERDICT_BAD_VERSION, 8'h00, 6'd60}},
    '{16'h4000, 1'b1, 1'b1, {VERDICT_BAD_HLEN, 8'h00, 6'd0}},
    '{16'h4400, 1'b1, 1'b1, {VERDICT_BAD_HLEN, 8'h00, 6'd16}},
    '{16'hffff, 1'b0, 1'b0, NoRes},
    '{16'h4500, 1'b1, 1'b0, NoRes},
    '{16'h001c, 1'b0, 1'b0, NoRes},
    '{16'h0000, 1'b0, 1'b0, NoRes},
    '{16'h0000, 1'b0, 1'b0, NoRes},
    '{16'h4001, 1'b0, 1'b0, NoRes},
    '{16'h66df, 1'b0, 1'b0, NoRes},
    '{16'h0a00, 1'b0, 1'b0, NoRes},
    '{16'h0001, 1'b0, 1'b0, NoRes},
    '{16'h0a00, 1'b0, 1'b0, NoRes},
    '{16'h0002, 1'b0, 1'b1, {VERDICT_OK_ICMP, 8'h01, 6'd20}},
    '{16'h4500, 1'b1, 1'b0, NoRes},
    '{16'h001c, 1'b0, 1'b0, NoRes},
    '{16'h0000, 1'b0, 1'b0, NoRes},
    '{16'h4500, 1'b1, 1'b0, NoRes},
    '{16'hffff, 1'b0, 1'b0, NoRes},
    '{16'hffff, 1'b0, 1'b0, NoRes},
    '{16'hffff, 1'b0, 1'b0, NoRes},
    '{16'hffff, 1'b0, 1'b0, NoRes},
    '{16'hffff, 1'b0, 1'b0, NoRes},
    '{16'hffff, 1'b0, 1'b0, NoRes},
    '{16'hffff, 1'b0, 1'b0, NoRes},
    '{16'hffff, 1'b0, 1'b0, NoRes},
    '{16'hffff, 1'b0, 1'b1, {VERDICT_BAD_CHECKSUM, 8'hff, 6'd20}}
  };

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    s = {1'b0, s[15:0]} + {16'd0, s[16]};
    return s[15:0];
  endfunction

  function automatic bit predict_verdict(input logic [15:0] w, input logic f,
                                         output result_t r);
    r = NoRes;
    if (f) begin
      hdr_open      = 1'b0;
      hdr_taken     = '0;
      hdr_len_words = '0;
      hdr_sum       = '0;
      hdr_proto     = '0;
      r.header_bytes = {w[11:8], 2'b00};
      if (w[15:12] != IpVersionOk) begin
        r.verdict = VERDICT_BAD_VERSION;
        return 1'b1;
      end
      if (w[11:8] < MinIhl) begin
        r.verdict = VERDICT_BAD_HLEN;
        return 1'b1;
      end
      hdr_open      = 1'b1;
      hdr_len_words = {w[11:8], 1'b0};
      hdr_sum       = w;
      hdr_taken     = 5'd1;
      return 1'b0;
    end
    if (!hdr_open) return 1'b0;
    hdr_sum = oc_add(hdr_sum, w);
    if (hdr_taken == ProtoWordIdx) hdr_proto = w[7:0];
    hdr_taken = hdr_taken + 5'd1;
    if (hdr_taken != hdr_len_words) return 1'b0;
    hdr_open = 1'b0;
    r.protocol     = hdr_proto;
    r.header_bytes = {hdr_len_words, 1'b0};
    if (hdr_sum != OnesMask) r.verdict = VERDICT_BAD_CHECKSUM;
    else if (hdr_proto == ProtoNumIcmp) r.verdict = VERDICT_OK_ICMP;
    else if (hdr_proto == ProtoNumTcp) r.verdict = VERDICT_OK_TCP;
    else r.verdict = VERDICT_OK_OTHER;
    return 1'b1;
  endfunction

  task automatic send_word(input logic [15:0] w, input logic f, input logic typed,
                           input result_t want);
    int      gap;
    result_t r;
    gap = tx_gapless ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    word_i     <= w;
    first_i    <= f;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_verdict(w, f, r)) verdict_q.push_back(typed ? want : r);
    sent_items++;
  endtask

  task automatic send_random_packet();
    logic [15:0] hdr_w [30];
    logic [15:0] sum;
    logic [3:0]  ihl;
    logic [3:0]  ver;
    logic [7:0]  proto;
    int          kind;
    int          nw;
    int          trail;
    kind  = $urandom_range(0, 99);
    ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    nw    = 2 * ihl;
    trail = $urandom_range(0, 3);
    if (kind < 80) begin
      for (int i = 0; i < nw; i++) hdr_w[i] = 16'($urandom);
      hdr_w[0][15:8] = {IpVersionOk, ihl};
      case ($urandom_range(0, 3))
        0: proto = ProtoNumIcmp;
        1: proto = ProtoNumTcp;
        default: proto = 8'($urandom);
      endcase
      hdr_w[4][7:0] = proto;
      sum = '0;
      for (int i = 0; i < nw; i++) if (i != 5) sum = oc_add(sum, hdr_w[i]);
      hdr_w[5] = ~sum;
      if ($urandom_range(0, 6) == 0) hdr_w[5] = hdr_w[5] ^ 16'($urandom_range(1, 65535));
      // truncated header, dropped by the next flagged word
      if (kind >= 70) nw = $urandom_range(1, nw - 1);
      for (int i = 0; i < nw; i++) send_word(hdr_w[i], i == 0, 1'b0, NoRes);
    end else if (kind < 90) begin
      ver = 4'($urandom);
      if (ver == IpVersionOk) ver = ver ^ 4'h8;
      send_word({ver, 12'($urandom)}, 1'b1, 1'b0, NoRes);
    end else begin
      send_word({IpVersionOk, 4'($urandom_range(0, 4)), 8'($urandom)}, 1'b1, 1'b0, NoRes);
    end
    for (int i = 0; i < trail; i++) send_word(16'($urandom), 1'b0, 1'b0, NoRes);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** ipv4_header_receive_checker_unit: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int      rx_wait;
    int      rx_hold;
    bit      rx_fast;
    result_t want;
    rx_wait = 0;
    rx_hold = 0;
    rx_fast = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold     = LongHold;
        rx_hold_req = 1'b0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result verdict %0d protocol %0h bytes %0d",
                   $time, verdict_o, protocol_o, header_bytes_o);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (verdict_o !== want.verdict) begin
            $display("%0t: verdict expected %0d got %0d", $time, want.verdict, verdict_o);
            errors++;
          end
          if (protocol_o !== want.protocol) begin
            $display("%0t: protocol expected %0h got %0h", $time, want.protocol, protocol_o);
            errors++;
          end
          if (header_bytes_o !== want.header_bytes) begin
            $display("%0t: header_bytes expected %0d got %0d",
                     $time, want.header_bytes, header_bytes_o);
            errors++;
          end
        end
        if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
        rx_wait = rx_fast ? 0 : $urandom_range(0, 5);
      end
    end
  end

  initial begin
    int  burst_left;
    bit  held;
    bit  paused;
    burst_left = 0;
    held       = 1'b0;
    paused     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].first, dir_rows[i].typed, dir_rows[i].want);

    while (sent_items < ItemTarget) begin
      if (!held && sent_items >= 500) begin
        held        = 1'b1;
        rx_hold_req = 1'b1;
        burst_left  = 40;
      end
      if (!paused && sent_items >= 900) begin
        paused = 1'b1;
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk_i);
      end
      if (burst_left > 0) begin
        burst_left--;
        tx_gapless = 1'b1;
      end else begin
        tx_gapless = ($urandom_range(0, 3) == 0);
      end
      send_random_packet();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("** ipv4_header_receive_checker_unit: PASSED **");
    end else begin
      $display("** ipv4_header_receive_checker_unit: FAILED **");
    end
    $finish;
  end

endmodule
